[rtl/sdrb_pkg.sv]
// shared types, widths and codes for the standard deviation backward block
// used by sdrb_div and std_dev_reduce_backward
package sdrb_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int DIV_W          = 64;
    localparam int SUM_W          = 48;
    localparam int ROOT_STEPS     = 48;
    localparam int RAD_W          = 2 * ROOT_STEPS;
    localparam int OUTER_W        = 9;
    localparam int AXIS_W         = 11;
    localparam int INNER_W        = 9;
    localparam int DDOF_W         = 10;
    localparam int GRP_W          = OUTER_W + INNER_W;
    localparam int TOT_W          = GRP_W + AXIS_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DEF_MAX_ELEMS  = 1024;
    localparam int DEF_MAX_GROUPS = 256;

    localparam logic [DIV_W-1:0] SAT_POS = (DIV_W'(1) << (DATA_WIDTH - 1)) - DIV_W'(1);
    localparam logic [DIV_W-1:0] SAT_NEG = DIV_W'(1) << (DATA_WIDTH - 1);

    // request codes
    localparam logic [1:0] REQ_ELEM  = 2'd0;
    localparam logic [1:0] REQ_GRAD  = 2'd1;
    localparam logic [1:0] REQ_FETCH = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DDOF  = 3'd3;

    typedef enum logic [1:0] {
        PH_ELEMS,
        PH_GRADS,
        PH_READY
    } t_phase;

    typedef enum logic [4:0] {
        S_CFG,
        S_IDLE,
        S_SUM_RD,
        S_SUM_WR,
        S_MEAN_RD,
        S_MEAN_ST,
        S_MEAN_DIV,
        S_MEAN_WR,
        S_VAR_RD,
        S_VAR_D,
        S_VAR_MUL,
        S_VAR_WR,
        S_ROOT_RD,
        S_ROOT_ST,
        S_ROOT_DIV,
        S_ROOT_SQ,
        S_ROOT_MUL,
        S_ROOT_WR,
        S_OUT_RD,
        S_OUT_D,
        S_OUT_MUL,
        S_OUT_ST,
        S_OUT_DIV,
        S_OUT_FIN
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/std_dev_reduce_backward.sv]
// top level of the standard deviation backward block
// depends on sdrb_pkg and sdrb_div
// Each element or gradient is stored as it is accepted, and a new one can follow at once.
// After the last element the block is busy with its statistics: a sum pass per element,
// a mean pass per group, a variance pass per element and a root pass per group (64-bit
// divide, then 48 root steps); mean, root and fetch passes share one iterative divider. A
// fetch divides unless the denominator is zero; a fetch that is not yet valid
// is answered next cycle. A register write restarts loading and holds off items in S_CFG.
module std_dev_reduce_backward #(
    parameter int MAX_ELEMS  = sdrb_pkg::DEF_MAX_ELEMS,
    parameter int MAX_GROUPS = sdrb_pkg::DEF_MAX_GROUPS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_req_type,
    input  logic signed [sdrb_pkg::DATA_WIDTH-1:0] i_in_value,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [sdrb_pkg::DATA_WIDTH-1:0] o_out_value,
    output logic                                   o_last_out,
    output logic [1:0]                             o_status,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sdrb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sdrb_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sdrb_pkg::*;

    localparam int EA = $clog2(MAX_ELEMS);
    localparam int EW = $clog2(MAX_ELEMS + 1);
    localparam int GA = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam int DW = DATA_WIDTH;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [1:0]         r_wait;
    logic [OUTER_W-1:0] r_outer;
    logic [AXIS_W-1:0]  r_axis;
    logic [INNER_W-1:0] r_inner;
    logic [DDOF_W-1:0]  r_ddof;
    logic [GRP_W-1:0]   r_groups;
    logic [TOT_W-1:0]   r_elems;

    logic [EW-1:0]      r_load_cnt;
    logic [GW-1:0]      r_grad_cnt;
    logic [EW-1:0]      r_idx;
    logic [GW-1:0]      r_gidx;
    logic [INNER_W-1:0] r_ci;
    logic [AXIS_W-1:0]  r_ca;
    logic [GW-1:0]      r_gbase;

    logic [DW-1:0]      r_elem_mem [MAX_ELEMS];
    logic [DW-1:0]      r_grad_mem [MAX_GROUPS];
    logic [SUM_W-1:0]   r_sum_mem  [MAX_GROUPS];
    logic [DIV_W-1:0]   r_sq_mem   [MAX_GROUPS];
    logic [DW-1:0]      r_elem_rd;
    logic [DW-1:0]      r_grad_rd;
    logic [SUM_W-1:0]   r_sum_rd;
    logic [DIV_W-1:0]   r_sq_rd;

    logic [DW+1:0]      r_d;
    logic [DIV_W-1:0]   r_prod;
    logic [DIV_W-1:0]   r_num;
    logic               r_neg;
    logic               r_mneg;
    logic [RAD_W-1:0]   r_rad;
    logic [ROOT_STEPS-1:0] r_root;
    logic [DIV_W-1:0]   r_rem;
    logic [5:0]         r_step;
    logic [DIV_W-1:0]   r_den;

    logic               r_out_valid;
    logic [DW-1:0]      r_out_value;
    logic               r_out_last;
    logic [1:0]         r_out_status;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic w_in_acc, w_cfg_hit, w_shape_ok;
    logic w_elem_ok, w_load_last, w_grad_ok, w_grad_last, w_fetch_ok;
    logic w_idx_last, w_gidx_last, w_ci_wrap, w_ca_wrap, w_dof_ok, w_den_zero;
    logic [AXIS_W-1:0]  w_dof;
    logic [GW-1:0]      w_g_full;
    logic [GA-1:0]      w_g, w_grp_addr;
    logic               w_elem_we, w_grad_we, w_sum_we, w_sq_we;
    logic [SUM_W-1:0]   w_sum_wd, w_sum_mag, w_mean;
    logic [DIV_W-1:0]   w_sq_wd;
    logic [DW+1:0]      w_d, w_dmag;
    logic [DW-1:0]      w_gmag;
    logic [DIV_W-1:0]   w_rem_sh, w_trial, w_qsat;
    logic [DW-1:0]      w_fin_value;
    logic [1:0]         w_fin_status;

    // ---------------- shape ----------------
    assign o_cfg_ready = 1'b1;
    assign w_cfg_hit = i_cfg_valid && (i_cfg_index == CFG_OUTER || i_cfg_index == CFG_AXIS ||
                       i_cfg_index == CFG_INNER || i_cfg_index == CFG_DDOF);

    always_ff @(posedge i_clk) begin
        r_groups <= GRP_W'(r_outer) * GRP_W'(r_inner);
        r_elems  <= TOT_W'(r_groups) * TOT_W'(r_axis);
    end

    assign w_shape_ok = (r_outer != '0) && (r_axis != '0) && (r_inner != '0) &&
                        (r_elems <= TOT_W'(MAX_ELEMS)) && (r_groups <= GRP_W'(MAX_GROUPS));

    assign w_in_acc    = i_valid && o_ready;
    assign w_elem_ok   = w_shape_ok && (r_phase == PH_ELEMS) && (TOT_W'(r_load_cnt) < r_elems);
    assign w_load_last = (TOT_W'(r_load_cnt) + TOT_W'(1)) == r_elems;
    assign w_grad_ok   = w_shape_ok && (r_phase == PH_GRADS) && (GRP_W'(r_grad_cnt) < r_groups);
    assign w_grad_last = (GRP_W'(r_grad_cnt) + GRP_W'(1)) == r_groups;
    assign w_fetch_ok  = w_shape_ok && (r_phase == PH_READY);

    // ---------------- traversal ----------------
    assign w_idx_last  = (TOT_W'(r_idx) + TOT_W'(1)) == r_elems;
    assign w_gidx_last = (GRP_W'(r_gidx) + GRP_W'(1)) == r_groups;
    assign w_ci_wrap   = ({1'b0, r_ci} + (INNER_W+1)'(1)) == {1'b0, r_inner};
    assign w_ca_wrap   = ({1'b0, r_ca} + (AXIS_W+1)'(1)) == {1'b0, r_axis};
    assign w_g_full    = r_gbase + GW'(r_ci);
    assign w_g         = w_g_full[GA-1:0];
    assign w_grp_addr  = (r_state inside {S_MEAN_RD, S_MEAN_ST, S_MEAN_DIV, S_MEAN_WR,
                          S_ROOT_RD, S_ROOT_ST, S_ROOT_DIV, S_ROOT_SQ, S_ROOT_MUL, S_ROOT_WR})
                         ? r_gidx[GA-1:0] : w_g;

    assign w_dof    = r_axis - AXIS_W'(r_ddof);
    assign w_dof_ok = AXIS_W'(r_ddof) < r_axis;
    assign w_den_zero = (r_sq_rd == '0);

    // ---------------- arithmetic ----------------
    assign w_d       = {{2{r_elem_rd[DW-1]}}, r_elem_rd} - r_sum_rd[DW+1:0];
    assign w_dmag    = r_d[DW+1] ? (~r_d + (DW+2)'(1)) : r_d;
    assign w_gmag    = r_grad_rd[DW-1] ? (~r_grad_rd + DW'(1)) : r_grad_rd;
    assign w_sum_mag = r_sum_rd[SUM_W-1] ? (~r_sum_rd + SUM_W'(1)) : r_sum_rd;
    assign w_mean    = r_mneg ? (~w_div_rsp.quot[SUM_W-1:0] + SUM_W'(1))
                              : w_div_rsp.quot[SUM_W-1:0];
    assign w_rem_sh  = {r_rem[DIV_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial   = DIV_W'({r_root, 2'b01});

    always_comb begin
        w_qsat       = w_div_rsp.quot;
        w_fin_status = ST_OK;
        if (w_den_zero) begin
            w_fin_status = ST_ZERO_DEN;
            if (r_num == '0) begin
                w_qsat = '0;
            end else if (r_neg) begin
                w_qsat = SAT_NEG;
            end else begin
                w_qsat = SAT_POS;
            end
        end else if (r_neg && w_div_rsp.quot > SAT_NEG) begin
            w_qsat = SAT_NEG;
        end else if (!r_neg && w_div_rsp.quot > SAT_POS) begin
            w_qsat = SAT_POS;
        end
        // zero numerator never carries a sign
        w_fin_value = (r_neg && r_num != '0) ? (~w_qsat[DW-1:0] + DW'(1)) : w_qsat[DW-1:0];
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CFG:      if (r_wait == 2'd0) n_state = S_IDLE;
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_req_type == REQ_ELEM && w_elem_ok && w_load_last) n_state = S_SUM_RD;
                    if (i_req_type == REQ_FETCH && w_fetch_ok) n_state = S_OUT_RD;
                end
            end
            S_SUM_RD:   n_state = S_SUM_WR;
            S_SUM_WR:   n_state = w_idx_last ? S_MEAN_RD : S_SUM_RD;
            S_MEAN_RD:  n_state = S_MEAN_ST;
            S_MEAN_ST:  n_state = S_MEAN_DIV;
            S_MEAN_DIV: if (w_div_rsp.done) n_state = S_MEAN_WR;
            S_MEAN_WR:  n_state = w_gidx_last ? S_VAR_RD : S_MEAN_RD;
            S_VAR_RD:   n_state = S_VAR_D;
            S_VAR_D:    n_state = S_VAR_MUL;
            S_VAR_MUL:  n_state = S_VAR_WR;
            S_VAR_WR:   n_state = w_idx_last ? S_ROOT_RD : S_VAR_RD;
            S_ROOT_RD:  n_state = S_ROOT_ST;
            S_ROOT_ST:  n_state = w_dof_ok ? S_ROOT_DIV : S_ROOT_MUL;
            S_ROOT_DIV: if (w_div_rsp.done) n_state = S_ROOT_SQ;
            S_ROOT_SQ:  if (r_step == 6'd0) n_state = S_ROOT_MUL;
            S_ROOT_MUL: n_state = S_ROOT_WR;
            S_ROOT_WR:  n_state = w_gidx_last ? S_IDLE : S_ROOT_RD;
            S_OUT_RD:   n_state = S_OUT_D;
            S_OUT_D:    n_state = S_OUT_MUL;
            S_OUT_MUL:  n_state = S_OUT_ST;
            S_OUT_ST:   n_state = w_den_zero ? S_OUT_FIN : S_OUT_DIV;
            S_OUT_DIV:  if (w_div_rsp.done) n_state = S_OUT_FIN;
            S_OUT_FIN:  n_state = S_IDLE;
            default:    n_state = S_CFG;
        endcase
        if (w_cfg_hit) n_state = S_CFG;
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_ready            = (r_state == S_IDLE) && !r_out_valid;
        w_elem_we          = 1'b0;
        w_grad_we          = 1'b0;
        w_sum_we           = 1'b0;
        w_sq_we            = 1'b0;
        w_sum_wd           = '0;
        w_sq_wd            = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_req_type == REQ_ELEM && w_elem_ok) w_elem_we = 1'b1;
                if (w_in_acc && i_req_type == REQ_GRAD && w_grad_ok) w_grad_we = 1'b1;
            end
            S_SUM_WR: begin
                w_sum_we = 1'b1;
                // first element of a group starts its sum
                w_sum_wd = ((r_ca == '0) ? '0 : r_sum_rd) +
                           {{(SUM_W-DW){r_elem_rd[DW-1]}}, r_elem_rd};
            end
            S_MEAN_ST: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DIV_W'(w_sum_mag);
                w_div_req.divisor  = DIV_W'(r_axis);
            end
            S_MEAN_WR: begin
                w_sum_we = 1'b1;
                w_sum_wd = w_mean;
            end
            S_VAR_WR: begin
                w_sq_we = 1'b1;
                w_sq_wd = ((r_ca == '0) ? '0 : r_sq_rd) + (r_prod >> FRAC_BITS);
            end
            S_ROOT_ST: begin
                w_div_req.start    = w_dof_ok;
                w_div_req.dividend = r_sq_rd;
                w_div_req.divisor  = DIV_W'(w_dof);
            end
            S_ROOT_WR: begin
                w_sq_we = 1'b1;
                w_sq_wd = r_den;
            end
            S_OUT_ST: begin
                w_div_req.start    = !w_den_zero;
                w_div_req.dividend = r_num;
                w_div_req.divisor  = r_sq_rd;
            end
            default: ;
        endcase
    end

    sdrb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (w_elem_we) r_elem_mem[r_load_cnt[EA-1:0]] <= i_in_value;
        r_elem_rd <= r_elem_mem[r_idx[EA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_grad_we) r_grad_mem[r_grad_cnt[GA-1:0]] <= i_in_value;
        r_grad_rd <= r_grad_mem[w_g];
    end

    // sums, then means in place
    always_ff @(posedge i_clk) begin
        if (w_sum_we) r_sum_mem[w_grp_addr] <= w_sum_wd;
        r_sum_rd <= r_sum_mem[w_grp_addr];
    end

    // squared sums, then denominators in place
    always_ff @(posedge i_clk) begin
        if (w_sq_we) r_sq_mem[w_grp_addr] <= w_sq_wd;
        r_sq_rd <= r_sq_mem[w_grp_addr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CFG;
            r_wait      <= 2'd2;
            r_phase     <= PH_ELEMS;
            r_out_valid <= 1'b0;
            r_outer     <= OUTER_W'(1);
            r_axis      <= AXIS_W'(1);
            r_inner     <= INNER_W'(1);
            r_ddof      <= '0;
            r_load_cnt  <= '0;
            r_grad_cnt  <= '0;
            r_idx       <= '0;
            r_gidx      <= '0;
            r_ci        <= '0;
            r_ca        <= '0;
            r_gbase     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CFG && r_wait != 2'd0) r_wait <= r_wait - 2'd1;
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_req_type)
                            REQ_ELEM: if (w_elem_ok) r_load_cnt <= r_load_cnt + EW'(1);
                            REQ_GRAD: begin
                                if (w_grad_ok) begin
                                    r_grad_cnt <= r_grad_cnt + GW'(1);
                                    if (w_grad_last) r_phase <= PH_READY;
                                end
                            end
                            REQ_FETCH: if (!w_fetch_ok) r_out_valid <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                S_SUM_WR, S_VAR_WR, S_OUT_FIN: begin
                    if (r_state == S_OUT_FIN) r_out_valid <= 1'b1;
                    if (w_idx_last) begin
                        r_idx   <= '0;
                        r_ci    <= '0;
                        r_ca    <= '0;
                        r_gbase <= '0;
                    end else begin
                        r_idx <= r_idx + EW'(1);
                        if (w_ci_wrap) begin
                            r_ci <= '0;
                            if (w_ca_wrap) begin
                                r_ca    <= '0;
                                r_gbase <= r_gbase + GW'(r_inner);
                            end else begin
                                r_ca <= r_ca + AXIS_W'(1);
                            end
                        end else begin
                            r_ci <= r_ci + INNER_W'(1);
                        end
                    end
                    // end of tensor: back to loading
                    if (r_state == S_OUT_FIN && w_idx_last) begin
                        r_phase    <= PH_ELEMS;
                        r_load_cnt <= '0;
                        r_grad_cnt <= '0;
                    end
                end
                S_MEAN_WR, S_ROOT_WR: begin
                    if (w_gidx_last) begin
                        r_gidx <= '0;
                        if (r_state == S_ROOT_WR) r_phase <= PH_GRADS;
                    end else begin
                        r_gidx <= r_gidx + GW'(1);
                    end
                end
                default: ;
            endcase
            if (w_cfg_hit) begin
                case (i_cfg_index)
                    CFG_OUTER: r_outer <= i_cfg_data[OUTER_W-1:0];
                    CFG_AXIS:  r_axis  <= i_cfg_data[AXIS_W-1:0];
                    CFG_INNER: r_inner <= i_cfg_data[INNER_W-1:0];
                    CFG_DDOF:  r_ddof  <= i_cfg_data[DDOF_W-1:0];
                    default: ;
                endcase
                r_wait     <= 2'd2;
                r_phase    <= PH_ELEMS;
                r_load_cnt <= '0;
                r_grad_cnt <= '0;
                r_idx      <= '0;
                r_gidx     <= '0;
                r_ci       <= '0;
                r_ca       <= '0;
                r_gbase    <= '0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_req_type == REQ_FETCH && !w_fetch_ok) begin
                    r_out_value  <= '0;
                    r_out_last   <= 1'b0;
                    r_out_status <= ST_NOT_READY;
                end
            end
            S_MEAN_ST: r_mneg <= r_sum_rd[SUM_W-1];
            S_VAR_D, S_OUT_D: r_d <= w_d;
            S_VAR_MUL: r_prod <= DIV_W'(w_dmag[DW-1:0]) * DIV_W'(w_dmag[DW-1:0]);
            S_OUT_MUL: begin
                r_num <= DIV_W'(w_gmag) * DIV_W'(w_dmag[DW:0]);
                r_neg <= r_grad_rd[DW-1] ^ r_d[DW+1];
            end
            S_ROOT_ST: begin
                r_root <= '0;
                r_rem  <= '0;
                r_step <= 6'(ROOT_STEPS - 1);
            end
            S_ROOT_DIV: begin
                if (w_div_rsp.done) r_rad <= RAD_W'({w_div_rsp.quot, FRAC_BITS'(0)});
            end
            S_ROOT_SQ: begin
                // one root bit per step from the top bit pair
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[ROOT_STEPS-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[ROOT_STEPS-2:0], 1'b0};
                end
                r_rad  <= r_rad << 2;
                r_step <= r_step - 6'd1;
            end
            S_ROOT_MUL: r_den <= DIV_W'(r_root) * DIV_W'(w_dof);
            S_OUT_FIN: begin
                r_out_value  <= w_fin_value;
                r_out_last   <= w_idx_last;
                r_out_status <= w_fin_status;
            end
            default: ;
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_last_out  = r_out_last;
    assign o_status    = r_out_status;

    // ---------------- assertions ----------------
    a_out_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE || r_state == S_CFG))
        else $error("result pending outside idle");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_phase == PH_READY) |-> (TOT_W'(r_load_cnt) == r_elems))
        else $error("fetch phase with incomplete element load");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_FIN) |=> o_valid)
        else $error("finished fetch produced no result");

endmodule

[rtl/sdrb_div.sv]
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on sdrb_pkg for the request and response structs
module sdrb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdrb_pkg::t_div_req i_req,
    output sdrb_pkg::t_div_rsp o_rsp
);
    import sdrb_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quot;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem[DIV_W-1:0], r_quot[DIV_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quot <= {r_quot[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
